### src/button_debounce_long_press_core_macros.svh
// Assertion macros shared by the debouncer checker.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BDLP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("bdlp check failed");

// Check a property on every clock edge, reset included.
`define BDLP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("bdlp check failed");

`endif

### src/bdlp_pkg.sv
// Shared types, constants and helper functions of the button debouncer.
package bdlp_pkg;

    localparam int CNT_W = 16;
    localparam int CFG_W = 16;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(50);
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(1500);
    localparam logic [CFG_W-1:0] REPEAT_RST = CFG_W'(500);

    localparam logic [IDX_W-1:0] REG_DEBOUNCE = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_REPEAT = IDX_W'(2);

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_RELEASED = 3'd2,
        EV_CLICK    = 3'd3,
        EV_LONG     = 3'd4,
        EV_REPEAT   = 3'd5
    } event_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] repeat_ticks;
    } cfg_t;

    typedef logic [CNT_W-1:0] cnt_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        cnt_t r;
        r = (v == CNT_MAX) ? v : v + cnt_t'(1);
        return r;
    endfunction

    function automatic logic reached(input cnt_t cnt, input logic [CFG_W-1:0] thr);
        logic r;
        r = (CMP_W'(cnt) >= CMP_W'(thr));
        return r;
    endfunction

endpackage

### src/bdlp_cfg.sv
// Configuration register file of the button debouncer.
module bdlp_cfg
    import bdlp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0] wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_DEBOUNCE:   cfg_next.debounce_ticks = wr_data;
                REG_LONG_PRESS: cfg_next.long_press_ticks = wr_data;
                REG_REPEAT:     cfg_next.repeat_ticks = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_RST;
            cfg_reg.repeat_ticks <= REPEAT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/bdlp_tracker.sv
// Debounce, press tracking and long-press/repeat state with its update logic.
module bdlp_tracker
    import bdlp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   step,
    input  logic   raw_level,
    input  cfg_t   cfg,
    output event_t event_code,
    output logic   is_pressed
);

    logic   prev_raw_reg, prev_raw_next;
    logic   stable_reg, stable_next;
    logic   long_reg, long_next;
    cnt_t   settle_reg, settle_next;
    cnt_t   held_reg, held_next;
    cnt_t   rep_reg, rep_next;
    event_t ev;
    logic   want;
    logic   change;

    always_comb begin
        prev_raw_next = raw_level;
        settle_next = (raw_level != prev_raw_reg) ? '0 : sat_inc(settle_reg);
        held_next = sat_inc(held_reg);
        rep_next = sat_inc(rep_reg);
        stable_next = stable_reg;
        long_next = long_reg;
        ev = EV_NONE;
        want = ~raw_level;
        change = reached(settle_next, cfg.debounce_ticks) && (want != stable_reg);

        if (change) begin
            stable_next = want;
            if (want) begin
                held_next = '0;
                rep_next = '0;
                long_next = 1'b0;
                ev = EV_PRESSED;
            end else begin
                ev = long_reg ? EV_RELEASED : EV_CLICK;
            end
        end else if (stable_reg) begin
            if (!long_reg && reached(held_next, cfg.long_press_ticks)) begin
                long_next = 1'b1;
                rep_next = '0;
                ev = EV_LONG;
            end else if (long_reg && reached(rep_next, cfg.repeat_ticks)) begin
                rep_next = '0;
                ev = EV_REPEAT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg <= 1'b1;
            stable_reg <= 1'b0;
            long_reg <= 1'b0;
            settle_reg <= CNT_MAX;
            held_reg <= '0;
            rep_reg <= '0;
        end else if (step) begin
            prev_raw_reg <= prev_raw_next;
            stable_reg <= stable_next;
            long_reg <= long_next;
            settle_reg <= settle_next;
            held_reg <= held_next;
            rep_reg <= rep_next;
        end
    end

    assign event_code = ev;
    assign is_pressed = stable_next;

endmodule

### src/button_debounce_long_press_core.sv
// Top level of the button debouncer with long-press and repeat events.
// Path: an accepted input waits in the input register and moves to the result register once the result slot is free.
// Throughput: one item per cycle while m_ready is high; the state update is a single pass of compares
// and saturating increments between the input register and the result register.
// Reset: synchronous, active low; clears both pipeline valids, loads the register
// defaults (50, 1500, 500) and returns the tracker to released with settle saturated.
module button_debounce_long_press_core
    import bdlp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // input item channel
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_raw_level,
    // result item channel
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_event_code,
    output logic             m_is_pressed,
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t   cfg;
    logic   in_valid_reg, in_valid_next;
    logic   in_raw_reg, in_raw_next;
    logic   out_valid_reg, out_valid_next;
    event_t out_event_reg, out_event_next;
    logic   out_pressed_reg, out_pressed_next;
    logic   advance;
    event_t step_event;
    logic   step_pressed;

    // Configuration writes are always taken; the host must write only while idle, unchecked here.
    assign cfg_ready = 1'b1;

    bdlp_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the held item into the result register when the result slot is free
    // or being drained this cycle; the tracker state advances on the same edge.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // Take a new item whenever the input register empties or moves forward.
    assign s_ready = !in_valid_reg || advance;

    bdlp_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .raw_level  (in_raw_reg),
        .cfg        (cfg),
        .event_code (step_event),
        .is_pressed (step_pressed)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_raw_next = in_raw_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_raw_next = s_raw_level;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;
        out_pressed_next = out_pressed_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_event_next = step_event;
            out_pressed_next = step_pressed;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control: valids cleared on reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold until replaced, no reset.
    always_ff @(posedge aclk) begin
        in_raw_reg <= in_raw_next;
        out_event_reg <= out_event_next;
        out_pressed_reg <= out_pressed_next;
    end

    assign m_valid = out_valid_reg;
    assign m_event_code = out_event_reg;
    assign m_is_pressed = out_pressed_reg;

endmodule

### src/bdlp_checker.sv
// Port-level checker for the button debouncer, bound to the top level.
`include "button_debounce_long_press_core_macros.svh"

module bdlp_checker
    import bdlp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_event_code,
    input logic       m_is_pressed
);

    logic       press_ev;
    logic       release_ev;
    logic [3:0] result_bits;

    assign press_ev = (m_event_code == EV_PRESSED) || (m_event_code == EV_LONG)
                      || (m_event_code == EV_REPEAT);
    assign release_ev = (m_event_code == EV_CLICK) || (m_event_code == EV_RELEASED);
    assign result_bits = {m_event_code, m_is_pressed};

    // No result may appear in the cycle after reset.
    `BDLP_ASSERT_ALWAYS(a_no_result_after_reset, !aresetn |=> !m_valid)
    // A stalled result holds its value.
    `BDLP_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(result_bits))
    // Press, long-press and repeat events only while pressed.
    `BDLP_ASSERT(a_press_state, m_valid && press_ev |-> m_is_pressed)
    // Click and release events only once released.
    `BDLP_ASSERT(a_release_state, m_valid && release_ev |-> !m_is_pressed)
    // Event codes stay within the defined set.
    `BDLP_ASSERT(a_code_range, m_valid |-> m_event_code <= EV_REPEAT)

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (.*);

### sim/tb.sv
// Self-checking testbench of the button debouncer with long-press and repeat events.
`timescale 1ns / 100ps

module tb;
    import bdlp_pkg::*;

    // Register index that decodes to no register; writes to it must be dropped.
    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(3);

    localparam int unsigned RESET_CYCLES = 11;
    // Two pipeline stages inside the block; leave a settling margin before
    // touching the registers or ending the run.
    localparam int unsigned SETTLE_CYCLES = 8;
    // Receiver hold-off long enough to fill both pipeline stages and stall s_ready.
    localparam int unsigned HOLD_CYCLES = 250;
    // Slowest run: ~1350 items, slowed when both sides idle at random, plus
    // the hold-off and register writes. Taken many times over.
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned PRINT_LIMIT = 100;

    typedef enum int unsigned {
        PACE_FULL,
        PACE_TX_IDLE,
        PACE_RX_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        event_t code;
        logic   pressed;
    } tick_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_raw_level = 1'b1;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [2:0]       m_event_code;
    logic             m_is_pressed;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = REG_DEBOUNCE;
    logic [CFG_W-1:0] cfg_data = '0;

    button_debounce_long_press_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_level  (s_raw_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .m_is_pressed (m_is_pressed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Raw samples waiting to be offered, and events the tracker predicts.
    logic         pending_levels[$];
    tick_result_t expected_events[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_token = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Tracker copy of the block: thresholds and debounce / hold state.
    cfg_t limits = '{DEBOUNCE_RST, LONG_PRESS_RST, REPEAT_RST};
    logic trk_prev_raw = 1'b1;
    logic trk_pressed = 1'b0;
    logic trk_long = 1'b0;
    cnt_t trk_settle = CNT_MAX;
    cnt_t trk_held = '0;
    cnt_t trk_repeat = '0;

    function automatic cnt_t count_up(input cnt_t v);
        return (v == CNT_MAX) ? v : v + cnt_t'(1);
    endfunction

    // Advance the tracker by one raw sample and return the event of that tick.
    function automatic tick_result_t track_tick(input logic raw);
        tick_result_t res;
        logic         want;
        logic         decided;
        res.code = EV_NONE;
        decided = 1'b0;
        trk_settle = (raw != trk_prev_raw) ? cnt_t'(0) : count_up(trk_settle);
        trk_held = count_up(trk_held);
        trk_repeat = count_up(trk_repeat);
        trk_prev_raw = raw;
        // Accept the raw level once it has been steady long enough.
        if (trk_settle >= limits.debounce_ticks) begin
            want = ~raw;
            if (want != trk_pressed) begin
                trk_pressed = want;
                if (want) begin
                    trk_held = '0;
                    trk_repeat = '0;
                    trk_long = 1'b0;
                    res.code = EV_PRESSED;
                end else begin
                    res.code = trk_long ? EV_RELEASED : EV_CLICK;
                end
                decided = 1'b1;
            end
        end
        // A press or release event owns the tick; otherwise check hold timing.
        if (!decided && trk_pressed) begin
            if (!trk_long && trk_held >= limits.long_press_ticks) begin
                trk_long = 1'b1;
                trk_repeat = '0;
                res.code = EV_LONG;
            end else if (trk_long && trk_repeat >= limits.repeat_ticks) begin
                trk_repeat = '0;
                res.code = EV_REPEAT;
            end
        end
        res.pressed = trk_pressed;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        // Keep the log short; every mismatch still counts.
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        mismatch_count++;
    endtask

    // Driver: hold the item until accepted, predict on accept, then load the
    // next sample or drop s_valid.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_raw_level <= 1'b1;
        end else begin
            if (s_valid && s_ready) begin
                expected_events.push_back(track_tick(s_raw_level));
            end
            if (!s_valid || s_ready) begin
                if (pending_levels.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_raw_level <= pending_levels.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off each time hold_token flips.
    int unsigned hold_left = 0;
    logic        hold_seen = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
            hold_seen = hold_token;
        end else begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Monitor: compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_check
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result event=%0d pressed=%0b",
                                          m_event_code, m_is_pressed));
            end else begin
                want = expected_events.pop_front();
                if (m_event_code !== want.code) begin
                    report_mismatch($sformatf("event_code got %0d want %0d",
                                              m_event_code, want.code));
                end
                if (m_is_pressed !== want.pressed) begin
                    report_mismatch($sformatf("is_pressed got %0b want %0b",
                                              m_is_pressed, want.pressed));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Wait until every sample has gone through and every result has come back.
    // Look between edges so the driver and monitor updates of an edge are settled.
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_levels.size() != 0 || s_valid || expected_events.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE:   limits.debounce_ticks = value;
            REG_LONG_PRESS: limits.long_press_ticks = value;
            REG_REPEAT:     limits.repeat_ticks = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                             input logic [CFG_W-1:0] rep);
        wait_idle();
        write_register(REG_DEBOUNCE, deb);
        write_register(REG_UNUSED, CFG_W'($urandom));
        write_register(REG_LONG_PRESS, lng);
        write_register(REG_REPEAT, rep);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FULL: begin
                tx_idle_pct <= 0;
                rx_stall_pct <= 0;
            end
            PACE_TX_IDLE: begin
                tx_idle_pct <= 67;
                rx_stall_pct <= 0;
            end
            PACE_RX_STALL: begin
                tx_idle_pct <= 0;
                rx_stall_pct <= 67;
            end
            default: begin
                tx_idle_pct <= 30;
                rx_stall_pct <= 30;
            end
        endcase
    endtask

    // Queue a fixed sample pattern, most significant bit first.
    task automatic queue_pattern(input logic [31:0] pattern, input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) begin
            pending_levels.push_back(pattern[count - 1 - k]);
        end
    endtask

    // Queue press / release sequences shaped around the current thresholds:
    // contact bounce, then a steady level long enough to be accepted and, for
    // presses, to reach long-press and repeats. Mix in noise bursts and runs
    // too short to settle.
    task automatic queue_presses(input int unsigned count, input int unsigned cap);
        int unsigned pushed;
        int unsigned run;
        int unsigned k;
        int unsigned deb;
        int unsigned lng;
        int unsigned rep;
        logic        level;
        pushed = 0;
        level = 1'b1;
        deb = limits.debounce_ticks;
        lng = limits.long_press_ticks;
        rep = limits.repeat_ticks;
        while (pushed < count) begin
            if ($urandom_range(0, 9) == 0) begin
                run = $urandom_range(1, 4);
                for (k = 0; k < run; k++) begin
                    pending_levels.push_back(1'($urandom));
                end
            end else begin
                level = ~level;
                for (k = $urandom_range(0, 2); k != 0; k--) begin
                    pending_levels.push_back(level);
                    pending_levels.push_back(~level);
                    pushed += 2;
                end
                if ($urandom_range(0, 7) == 0) begin
                    run = $urandom_range(1, deb + 1);
                end else if (!level) begin
                    run = $urandom_range(deb + 1, deb + lng + rep * $urandom_range(0, 4) + 4);
                end else begin
                    run = $urandom_range(deb + 1, deb + 4);
                end
                if (run > cap) begin
                    run = cap;
                end
                for (k = 0; k < run; k++) begin
                    pending_levels.push_back(level);
                end
            end
            pushed += run;
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                             input logic [CFG_W-1:0] rep, input pace_t pace,
                             input int unsigned count, input int unsigned cap);
        configure(deb, lng, rep);
        set_pace(pace);
        queue_presses(count, cap);
    endtask

    initial begin : stimulus
        int unsigned ph;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset thresholds: a bouncing contact never settles.
        set_pace(PACE_FULL);
        queue_pattern(32'b101, 3);

        // Zero thresholds: press on the first tick, long press on the next,
        // repeat on every tick after, then released, then a plain click.
        configure('0, '0, '0);
        queue_pattern(32'b0000_1101, 8);

        // Small thresholds: a glitch restarts the settle count, then a hold
        // through long press and repeats, and a bounced release.
        configure(CFG_W'(2), CFG_W'(3), CFG_W'(1));
        queue_pattern(32'b010_0000_0000_1011, 15);

        // Random press sequences under several settings and pacing modes.
        run_phase(CFG_W'(1), CFG_W'(6), CFG_W'(2), PACE_FULL, 130, 64);
        // Hold off the receiver while the sender keeps offering samples.
        hold_token <= ~hold_token;
        run_phase(CFG_W'(3), CFG_W'(10), CFG_W'(4), PACE_TX_IDLE, 130, 64);
        run_phase('0, '0, '0, PACE_RX_STALL, 130, 64);
        run_phase(CFG_W'(2), CFG_W'(5), '0, PACE_BOTH, 130, 64);
        // Largest thresholds: nothing settles within a short run.
        run_phase(CNT_MAX, CNT_MAX, CNT_MAX, PACE_FULL, 60, 40);
        // Instant debounce and long press, repeats never due.
        run_phase('0, CFG_W'(1), CNT_MAX, PACE_BOTH, 80, 64);
        for (ph = 0; ph < 5; ph++) begin
            run_phase(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 15)),
                      CFG_W'($urandom_range(0, 6)), pace_t'(ph % 4), 130, 64);
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
